// File: src/ilf_pkg.sv
// Shared constants and types for the indentation layout filter.
package ilf_pkg;

  localparam int MaxLevelsDefault = 32;
  localparam int ColW = 16;
  localparam int OffW = 32;

  typedef logic [1:0] kind_t;
  localparam kind_t KindToken   = 2'd0;
  localparam kind_t KindNewline = 2'd1;
  localparam kind_t KindIndent  = 2'd2;
  localparam kind_t KindDedent  = 2'd3;

  typedef logic [1:0] class_t;
  localparam class_t ClassPlain = 2'd0;
  localparam class_t ClassOpen  = 2'd1;
  localparam class_t ClassClose = 2'd2;
  localparam class_t ClassEof   = 2'd3;

  typedef logic [1:0] diag_t;
  localparam diag_t BrDiagNone      = 2'd0;
  localparam diag_t BrDiagAbandoned = 2'd1;
  localparam diag_t BrDiagUnclosed  = 2'd2;
  localparam diag_t LyDiagNone      = 2'd0;
  localparam diag_t LyDiagTooDeep   = 2'd1;
  localparam diag_t LyDiagNoLevel   = 2'd2;

  localparam logic [15:0] DepthMax = 16'hFFFF;

endpackage

// File: src/ilf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ilf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/indentation_layout_filter.sv
// Indentation layout filter: inserts NEWLINE, INDENT and DEDENT tokens by the offside rule.
// Each accepted item is captured in IDLE and classified in HEAD; results are registered at the output.
// Steps: IDLE, HEAD and TOK per item, plus CMP for the column compare of a new line and NL per NEWLINE.
// A pop run adds POP for its final check and POP plus POPW per DEDENT, for the registered stack read.
// Input is stalled while an item is in work; a stalled output holds the item in work.
// Reset clears the level stack to the single bottom level and all bracket state; no clearing pass.
module indentation_layout_filter #(
  parameter int MAX_LEVELS = ilf_pkg::MaxLevelsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ilf_pkg::class_t       tok_class_i,
  input  logic                  first_on_line_i,
  input  logic                  continuation_lead_i,
  input  logic [15:0]           column_i,
  input  logic [31:0]           src_offset_i,
  input  logic [15:0]           tok_length_i,
  input  logic [15:0]           token_code_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ilf_pkg::kind_t        out_kind_o,
  output logic [15:0]           out_code_o,
  output logic [15:0]           out_column_o,
  output logic [31:0]           out_offset_o,
  output logic [15:0]           out_length_o,
  output ilf_pkg::diag_t        bracket_diag_o,
  output ilf_pkg::diag_t        layout_diag_o,
  output logic [31:0]           diag_offset_o,
  output logic [15:0]           nearest_column_o,
  output logic                  last_o
);
  import ilf_pkg::*;

  localparam int AW = $clog2(MAX_LEVELS);
  localparam logic [AW-1:0] TopMax = AW'(MAX_LEVELS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HEAD = 3'd1;
  localparam logic [2:0] S_NL   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_POP  = 3'd4;
  localparam logic [2:0] S_POPW = 3'd5;
  localparam logic [2:0] S_TOK  = 3'd6;

  logic [2:0]    state_q, state_d;
  class_t        cls_q;
  logic          fol_q, cont_q;
  logic [15:0]   col_q, len_q, code_q;
  logic [31:0]   off_q;

  logic [AW-1:0] top_q, top_d;
  logic [15:0]   top_col_q, top_col_d;
  logic [15:0]   depth_q, depth_d;
  logic [15:0]   bbc_q, bbc_d;
  logic [31:0]   opener_q, opener_d;
  logic          bfi_q, bfi_d;

  diag_t         bdiag_q, bdiag_d, ldiag_q, ldiag_d;
  logic [31:0]   doff_q, doff_d;
  logic [15:0]   nearest_q, nearest_d;

  logic          out_valid_q, out_valid_d;
  kind_t         out_kind_q;
  logic [15:0]   out_code_q, out_len_q, out_near_q;
  logic          out_last_q;
  diag_t         out_bdiag_q, out_ldiag_q;
  logic [31:0]   out_doff_q;

  logic          out_free;
  logic          emit;
  kind_t         emit_kind;
  logic          eof;
  logic          pop_more;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_rdata;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign eof        = (cls_q == ClassEof);
  assign pop_more   = (top_q != '0) && (eof || (top_col_q > col_q));

  ilf_ram #(
    .WIDTH(16),
    .DEPTH(MAX_LEVELS)
  ) u_levels (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(col_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    top_d     = top_q;
    top_col_d = top_col_q;
    depth_d   = depth_q;
    bbc_d     = bbc_q;
    opener_d  = opener_q;
    bfi_d     = bfi_q;
    bdiag_d   = bdiag_q;
    ldiag_d   = ldiag_q;
    doff_d    = doff_q;
    nearest_d = nearest_q;
    emit      = 1'b0;
    emit_kind = KindToken;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = AW'(top_q + 1'b1);
    ram_raddr = AW'(top_q - 1'b1);
    case (state_q)
      S_IDLE: begin
        bdiag_d   = BrDiagNone;
        ldiag_d   = LyDiagNone;
        doff_d    = '0;
        nearest_d = '0;
        if (in_valid_i) begin
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        if (eof) begin
          if (depth_q != '0) begin
            bdiag_d = BrDiagUnclosed;
            doff_d  = opener_q;
          end
          state_d = bfi_q ? S_POP : S_NL;
        end else if (fol_q) begin
          if (depth_q != '0 && !cont_q && col_q <= bbc_q) begin
            bdiag_d = BrDiagAbandoned;
            doff_d  = opener_q;
            depth_d = '0;
          end
          if (depth_d == '0) begin
            bfi_d = 1'b0;
            if (cont_q) begin
              state_d = S_POP;
            end else begin
              state_d = bfi_q ? S_CMP : S_NL;
            end
          end else begin
            state_d = S_TOK;
          end
        end else begin
          state_d = S_TOK;
        end
      end
      S_NL: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = KindNewline;
          state_d   = eof ? S_POP : S_CMP;
        end
      end
      S_CMP: begin
        if (col_q > top_col_q) begin
          if (top_q == TopMax) begin
            ldiag_d = LyDiagTooDeep;
            state_d = S_TOK;
          end else if (out_free) begin
            emit      = 1'b1;
            emit_kind = KindIndent;
            ram_we    = 1'b1;
            top_d     = AW'(top_q + 1'b1);
            top_col_d = col_q;
            state_d   = S_TOK;
          end
        end else if (col_q < top_col_q) begin
          state_d = S_POP;
        end else begin
          state_d = S_TOK;
        end
      end
      S_POP: begin
        if (pop_more) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_kind = KindDedent;
            ram_re    = 1'b1;
            top_d     = AW'(top_q - 1'b1);
            state_d   = S_POPW;
          end
        end else if (eof || cont_q || top_col_q == col_q) begin
          state_d = S_TOK;
        end else begin
          ldiag_d   = LyDiagNoLevel;
          nearest_d = top_col_q;
          if (top_q == TopMax) begin
            state_d = S_TOK;
          end else if (out_free) begin
            emit      = 1'b1;
            emit_kind = KindIndent;
            ram_we    = 1'b1;
            top_d     = AW'(top_q + 1'b1);
            top_col_d = col_q;
            state_d   = S_TOK;
          end
        end
      end
      S_POPW: begin
        top_col_d = (top_q == '0) ? 16'd1 : ram_rdata;
        state_d   = S_POP;
      end
      S_TOK: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = KindToken;
          state_d   = S_IDLE;
          if (eof) begin
            top_d     = '0;
            top_col_d = 16'd1;
            depth_d   = '0;
            bbc_d     = '0;
            opener_d  = '0;
            bfi_d     = 1'b1;
          end else if (cls_q == ClassOpen) begin
            if (depth_q == '0) begin
              bbc_d    = top_col_q;
              opener_d = off_q;
            end
            if (depth_q != DepthMax) begin
              depth_d = depth_q + 16'd1;
            end
          end else if (cls_q == ClassClose) begin
            if (depth_q != '0) begin
              depth_d = depth_q - 16'd1;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_q       <= '0;
      top_col_q   <= 16'd1;
      depth_q     <= '0;
      bbc_q       <= '0;
      opener_q    <= '0;
      bfi_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      top_col_q   <= top_col_d;
      depth_q     <= depth_d;
      bbc_q       <= bbc_d;
      opener_q    <= opener_d;
      bfi_q       <= bfi_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bdiag_q   <= bdiag_d;
    ldiag_q   <= ldiag_d;
    doff_q    <= doff_d;
    nearest_q <= nearest_d;
    if (state_q == S_IDLE && in_valid_i) begin
      cls_q  <= tok_class_i;
      fol_q  <= first_on_line_i;
      cont_q <= continuation_lead_i;
      col_q  <= column_i;
      off_q  <= src_offset_i;
      len_q  <= tok_length_i;
      code_q <= token_code_i;
    end
    if (emit) begin
      out_kind_q <= emit_kind;
      out_last_q <= (emit_kind == KindToken);
      out_code_q <= (emit_kind == KindToken) ? code_q : 16'd0;
      out_len_q  <= (emit_kind == KindToken) ? len_q : 16'd0;
      if (emit_kind == KindToken) begin
        out_bdiag_q <= bdiag_q;
        out_ldiag_q <= ldiag_q;
        out_doff_q  <= doff_q;
        out_near_q  <= nearest_q;
      end else begin
        out_bdiag_q <= BrDiagNone;
        out_ldiag_q <= LyDiagNone;
        out_doff_q  <= '0;
        out_near_q  <= '0;
      end
    end
  end

  logic [15:0] out_col_q;
  logic [31:0] out_off_q;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_col_q <= col_q;
      out_off_q <= off_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_kind_o       = out_kind_q;
  assign out_code_o       = out_code_q;
  assign out_column_o     = out_col_q;
  assign out_offset_o     = out_off_q;
  assign out_length_o     = out_len_q;
  assign bracket_diag_o   = out_bdiag_q;
  assign layout_diag_o    = out_ldiag_q;
  assign diag_offset_o    = out_doff_q;
  assign nearest_column_o = out_near_q;
  assign last_o           = out_last_q;

  // The bottom level always stands at column 1 once any pending pop read has landed.
  a_bottom_col : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_POPW && top_q == '0) |-> top_col_q == 16'd1)
    else $error("bottom level column is not 1");

  a_popw_after_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POPW) |-> ($past(state_q) == S_POP))
    else $error("pop wait state entered without a pop");

  a_last_is_token : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (out_kind_o == KindToken)))
    else $error("last flag does not match the copied token");

  a_diag_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (bracket_diag_o == BrDiagNone && layout_diag_o == LyDiagNone))
    else $error("diagnostics on a result that is not the last");

  a_tok_ends_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TOK && out_free) |=> state_q == S_IDLE)
    else $error("item did not finish after its token transfer");

endmodule
